@@ rtl/grouped_byte_bit_rotator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Grouped byte bit rotator assertion macros
// Concurrent check macros on clk / arst_n; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef GROUPED_BYTE_BIT_ROTATOR_UNIT_ASSERT_SVH
`define GROUPED_BYTE_BIT_ROTATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// pre holds at an edge -> post holds at the same edge
`define GBR_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("grouped byte bit rotator check failed");

// pre holds at an edge -> post holds at the next edge
`define GBR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("grouped byte bit rotator check failed");

`else

`define GBR_ASSERT_SAME(lbl, pre, post)
`define GBR_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

@@ rtl/gbr_pkg.sv @@
// ----------------------------------------------------------------------------
// Grouped byte bit rotator package
// Sizes, register indexes and the group item carried down the cell chain.
// ----------------------------------------------------------------------------
package gbr_pkg;

	localparam int GROUP_MAX  = 16;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = $clog2(GROUP_MAX + 1);  // byte count, 1..GROUP_MAX
	localparam int IDX_W      = $clog2(GROUP_MAX);      // byte index in a group
	localparam int REM_W      = IDX_W;                  // remainder < count
	localparam int AMT_W      = 12;                     // rotate_amount width
	localparam int GSIZE_W    = 5;                      // group_bytes width
	localparam int BIT_W      = 3;                      // bit offset in a byte
	localparam int DVD_W      = AMT_W - BIT_W;          // whole bytes of the count
	localparam int MOD_STAGES = DVD_W;                  // one cell per dividend bit
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GROUP_BYTES   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE_AMOUNT = 1'b1;

	typedef logic [BYTE_W-1:0] octet_t;
	typedef octet_t [GROUP_MAX-1:0] group_t;

	// One completed group on its way to the emitter
	typedef struct packed {
		group_t            bytes;
		logic [CNT_W-1:0]  cnt;      // bytes in the group
		logic [REM_W-1:0]  rem;      // running remainder of dvd mod cnt
		logic [DVD_W-1:0]  dvd;      // dividend bits still to shift in, MSB first
		logic [BIT_W-1:0]  bit_ofs;  // count magnitude mod 8
		logic              rot_left; // rotate toward the MSB end
	} grp_item_t;

	typedef struct packed {
		logic      valid;
		grp_item_t item;
	} link_t;

endpackage

@@ rtl/grouped_byte_bit_rotator_unit.sv @@
// Path: the byte that closes a group pushes it straight into the nine modulo cells,
//   then into the emitter register, which drives the group's first output byte.
// Throughput: one byte per cycle in and out while neither side is stalled; emission
//   of a group overlaps collection of the next; the emitter's port sets the output rate.
// Reset: drops any partly collected group and all groups in flight;
//   group_bytes returns to 1 and rotate_amount to 0.
// ----------------------------------------------------------------------------
// Grouped byte bit rotator
// Collects bytes into groups of group_bytes, rotates each full group as one
// big-endian bit string by rotate_amount bits, and emits it byte by byte.
// ----------------------------------------------------------------------------
`include "grouped_byte_bit_rotator_unit_assert.svh"

module grouped_byte_bit_rotator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_byte
	input  logic                            s_tlast,   // section_end
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] out_byte
	output logic                            m_tlast,   // out_last
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbr_pkg::AMT_W-1:0]       cfg_data
);

	// Configuration registers. rotate_amount is two's complement: a positive
	// count rotates right, zero or negative rotates left by the magnitude.
	logic [gbr_pkg::GSIZE_W-1:0] group_bytes_q;
	logic [gbr_pkg::AMT_W-1:0]   rotate_amount_q;

	// chain[0] is the collector output, chain[i+1] the output of modulo cell i,
	// chain[MOD_STAGES] feeds the emitter. rdy[i] is the ready into chain[i].
	gbr_pkg::link_t chain [0:gbr_pkg::MOD_STAGES];
	logic           rdy   [0:gbr_pkg::MOD_STAGES];
	logic           in_fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_bytes_q   <= gbr_pkg::GSIZE_W'(1);
			rotate_amount_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gbr_pkg::REG_GROUP_BYTES: begin
					group_bytes_q <= cfg_data[gbr_pkg::GSIZE_W-1:0];
				end
				gbr_pkg::REG_ROTATE_AMOUNT: begin
					rotate_amount_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Input side: a byte is taken whenever the first cell has room, so the
	// collector never holds a finished group of its own.
	assign s_tready = rdy[0];
	assign in_fire  = s_tvalid && s_tready;

	gbr_collect u_collect (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.data_byte     (s_tdata),
		.section_end   (s_tlast),
		.group_bytes   (group_bytes_q),
		.rotate_amount (rotate_amount_q),
		.push          (chain[0])
	);

	// Modulo chain: each cell shifts one bit of the whole-byte count into a
	// remainder against the group size, so the last cell holds count mod size.
	for (genvar i = 0; i < gbr_pkg::MOD_STAGES; i++) begin : g_cell
		gbr_mod_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.din        (chain[i]),
			.din_ready  (rdy[i]),
			.dout       (chain[i+1]),
			.dout_ready (rdy[i+1])
		);
	end

	// Emitter: turns the remainder into a byte offset and a bit offset and
	// sends one rotated byte per cycle while m_tready is high, tlast on the last byte.
	gbr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (chain[gbr_pkg::MOD_STAGES]),
		.din_ready (rdy[gbr_pkg::MOD_STAGES]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

	// a closed group always lands in the first cell
	`GBR_ASSERT_NEXT(a_push_lands, chain[0].valid, chain[1].valid)
	// a group waiting at the chain end is never dropped
	`GBR_ASSERT_NEXT(a_chain_end_holds,
		chain[gbr_pkg::MOD_STAGES].valid && !rdy[gbr_pkg::MOD_STAGES],
		chain[gbr_pkg::MOD_STAGES].valid)
	// the emitter picks up the waiting group right after finishing one
	`GBR_ASSERT_NEXT(a_group_handoff,
		m_tvalid && m_tready && m_tlast && chain[gbr_pkg::MOD_STAGES].valid, m_tvalid)
	// the collector only pushes when the first cell can take the group
	`GBR_ASSERT_SAME(a_push_has_room, chain[0].valid, rdy[0] && s_tvalid)

endmodule

@@ rtl/gbr_collect.sv @@
// ----------------------------------------------------------------------------
// Group collector
// Gathers bytes into a group and hands the finished group to the cell chain.
// ----------------------------------------------------------------------------
module gbr_collect (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_fire,
	input  gbr_pkg::octet_t                 data_byte,
	input  logic                            section_end,
	input  logic [gbr_pkg::GSIZE_W-1:0]     group_bytes,
	input  logic [gbr_pkg::AMT_W-1:0]       rotate_amount,
	output gbr_pkg::link_t                  push
);

	logic [gbr_pkg::IDX_W-1:0] fill_q;
	gbr_pkg::group_t           store_q;
	gbr_pkg::group_t           grp;
	logic [gbr_pkg::CNT_W-1:0] size_eff;
	logic [gbr_pkg::CNT_W-1:0] cnt;
	logic [gbr_pkg::AMT_W-1:0] mag;
	logic                      rot_right;
	logic                      full;
	logic                      done;

	always_comb begin
		priority if (group_bytes == '0) begin
			size_eff = gbr_pkg::CNT_W'(1);
		end else if (gbr_pkg::CNT_W'(group_bytes) > gbr_pkg::CNT_W'(gbr_pkg::GROUP_MAX)) begin
			size_eff = gbr_pkg::CNT_W'(gbr_pkg::GROUP_MAX);
		end else begin
			size_eff = gbr_pkg::CNT_W'(group_bytes);
		end
	end

	assign cnt  = gbr_pkg::CNT_W'(fill_q) + gbr_pkg::CNT_W'(1);
	assign full = (cnt >= size_eff);
	assign done = full || section_end;

	// two's complement magnitude; the most negative code maps to 2048
	assign mag       = rotate_amount[gbr_pkg::AMT_W-1] ?
	                   (gbr_pkg::AMT_W'(0) - rotate_amount) : rotate_amount;
	assign rot_right = !rotate_amount[gbr_pkg::AMT_W-1] && (rotate_amount != '0);

	always_comb begin
		grp         = store_q;
		grp[fill_q] = data_byte;
	end

	always_comb begin
		push.valid      = in_fire && done;
		push.item.bytes = grp;
		push.item.cnt   = cnt;
		push.item.rem   = '0;
		if (full) begin
			push.item.dvd      = mag[gbr_pkg::AMT_W-1:gbr_pkg::BIT_W];
			push.item.bit_ofs  = mag[gbr_pkg::BIT_W-1:0];
			push.item.rot_left = !rot_right;
		end else begin
			// partial group at section end leaves unrotated
			push.item.dvd      = '0;
			push.item.bit_ofs  = '0;
			push.item.rot_left = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_fire) begin
			fill_q <= done ? '0 : fill_q + gbr_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			store_q[fill_q] <= data_byte;
		end
	end

endmodule

@@ rtl/gbr_mod_cell.sv @@
// ----------------------------------------------------------------------------
// Modulo cell
// One restoring step of (byte count) mod (group size); holds one group.
// ----------------------------------------------------------------------------
module gbr_mod_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  gbr_pkg::link_t din,
	output logic           din_ready,
	output gbr_pkg::link_t dout,
	input  logic           dout_ready
);

	logic                      valid_q;
	gbr_pkg::grp_item_t        item_q;
	gbr_pkg::grp_item_t        nxt;
	logic [gbr_pkg::CNT_W-1:0] trial;

	// shift next dividend bit into the remainder, subtract group size if it fits
	always_comb begin
		trial = {din.item.rem, din.item.dvd[gbr_pkg::DVD_W-1]};
		nxt   = din.item;
		if (trial >= din.item.cnt) begin
			nxt.rem = gbr_pkg::REM_W'(trial - din.item.cnt);
		end else begin
			nxt.rem = gbr_pkg::REM_W'(trial);
		end
		nxt.dvd = {din.item.dvd[gbr_pkg::DVD_W-2:0], 1'b0};
	end

	assign din_ready = !valid_q || dout_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (din_ready) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din_ready && din.valid) begin
			item_q <= nxt;
		end
	end

	assign dout.valid = valid_q;
	assign dout.item  = item_q;

endmodule

@@ rtl/gbr_emit.sv @@
// ----------------------------------------------------------------------------
// Group emitter
// Holds one group and sends its rotated bytes, one per cycle when out_ready.
// ----------------------------------------------------------------------------
module gbr_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  gbr_pkg::link_t  din,
	output logic            din_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output gbr_pkg::octet_t out_byte,
	output logic            out_last
);

	logic                      valid_q;
	logic [gbr_pkg::CNT_W-1:0] left_q;
	logic [gbr_pkg::IDX_W-1:0] idx_q;
	logic [gbr_pkg::CNT_W-1:0] cnt_q;
	logic [gbr_pkg::BIT_W-1:0] b_q;
	gbr_pkg::octet_t           prev_q;
	gbr_pkg::group_t           bytes_q;

	logic [gbr_pkg::IDX_W-1:0] ld_i0;
	logic [gbr_pkg::IDX_W-1:0] ld_i1;
	logic [gbr_pkg::BIT_W-1:0] ld_b;
	logic [gbr_pkg::CNT_W-1:0] q_inc;
	gbr_pkg::octet_t           cur;
	logic [2*gbr_pkg::BYTE_W-1:0] pair;
	logic [2*gbr_pkg::BYTE_W-1:0] pair_sh;
	logic                      fire;
	logic                      last;

	// Everything becomes a right rotation by 8*R + b bits; i0 is the byte
	// that supplies the low part of output byte 0, i1 the one before it.
	assign q_inc = gbr_pkg::CNT_W'(din.item.rem) + gbr_pkg::CNT_W'(1);

	always_comb begin
		if (din.item.rot_left) begin
			ld_b = gbr_pkg::BIT_W'(0) - din.item.bit_ofs;
			if (din.item.bit_ofs == '0) begin
				ld_i0 = din.item.rem;
			end else if (q_inc == din.item.cnt) begin
				ld_i0 = '0;
			end else begin
				ld_i0 = gbr_pkg::IDX_W'(q_inc);
			end
		end else begin
			ld_b = din.item.bit_ofs;
			if (din.item.rem == '0) begin
				ld_i0 = '0;
			end else begin
				ld_i0 = gbr_pkg::IDX_W'(din.item.cnt - gbr_pkg::CNT_W'(din.item.rem));
			end
		end
		if (ld_i0 == '0) begin
			ld_i1 = gbr_pkg::IDX_W'(din.item.cnt - gbr_pkg::CNT_W'(1));
		end else begin
			ld_i1 = ld_i0 - gbr_pkg::IDX_W'(1);
		end
	end

	assign fire      = valid_q && out_ready;
	assign last      = (left_q == gbr_pkg::CNT_W'(1));
	assign din_ready = !valid_q || (out_ready && last);

	assign cur       = bytes_q[idx_q];
	assign pair      = {prev_q, cur};
	assign pair_sh   = pair >> b_q;
	assign out_byte  = pair_sh[gbr_pkg::BYTE_W-1:0];
	assign out_valid = valid_q;
	assign out_last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			left_q  <= '0;
			idx_q   <= '0;
		end else if (din_ready) begin
			valid_q <= din.valid;
			if (din.valid) begin
				left_q <= din.item.cnt;
				idx_q  <= ld_i0;
			end
		end else if (fire) begin
			left_q <= left_q - gbr_pkg::CNT_W'(1);
			if (gbr_pkg::CNT_W'(idx_q) + gbr_pkg::CNT_W'(1) == cnt_q) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + gbr_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (din_ready && din.valid) begin
			bytes_q <= din.item.bytes;
			cnt_q   <= din.item.cnt;
			b_q     <= ld_b;
			prev_q  <= din.item.bytes[ld_i1];
		end else if (fire) begin
			prev_q  <= cur;
		end
	end

endmodule
